// ===== hw/rtl/fpfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfu_pkg: shared types and constants of the fixed-point function unit
// Command codes, sequencer states, Q16.16 constants and lookup tables.
// ----------------------------------------------------------------------------
package fpfu_pkg;

    localparam int DataW = 32;

    typedef enum logic [3:0] {
        CMD_SQRT  = 4'd0,
        CMD_ROUND = 4'd1,
        CMD_SIN   = 4'd2,
        CMD_COS   = 4'd3,
        CMD_EXP   = 4'd4,
        CMD_LN    = 4'd5,
        CMD_POW   = 4'd6,
        CMD_LOG10 = 4'd7,
        CMD_EXP10 = 4'd8
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_SQ_DS, ST_SQ_DW,
        ST_TR_FOLD, ST_TR_SQ, ST_TR_M1, ST_TR_M2, ST_TR_M3, ST_TR_END,
        ST_EX10, ST_EX_INIT, ST_EX_POW, ST_EX_DS, ST_EX_DW,
        ST_LN_PRE, ST_LN_CHK, ST_LN_DS, ST_LN_DW, ST_LN_FIN, ST_LN_POST,
        ST_OUT
    } state_t;

    localparam logic signed [31:0] FX_ONE     = 32'sd65536;
    localparam logic signed [31:0] FX_PI      = 32'sd205887;
    localparam logic signed [31:0] FX_PI_HALF = 32'sd102943;
    localparam logic signed [31:0] FX_PI_3H   = 32'sd308830;
    localparam logic signed [31:0] FX_PI_2    = 32'sd411774;
    localparam logic signed [31:0] FX_TWO     = 32'sd131072;
    localparam logic signed [31:0] FX_LOG10_E = 32'sh6f2e;
    localparam logic signed [31:0] FX_LN_10   = 32'sh24d76;
    localparam logic signed [31:0] SIN_K1     = 32'sd498;
    localparam logic signed [31:0] SIN_K2     = 32'sd10882;
    localparam logic signed [31:0] COS_K1     = 32'sd2328;
    localparam logic signed [31:0] COS_K2     = 32'sd32551;
    localparam logic [15:0]        LN_D0      = 16'h8000;

    // ln(1 + 2^-(k+1)) in Q16.16
    function automatic logic signed [31:0] ln_step(input logic [3:0] k);
        logic signed [31:0] v;
        case (k)
            4'd0:  v = 32'sd26573;
            4'd1:  v = 32'sd14624;
            4'd2:  v = 32'sd7719;
            4'd3:  v = 32'sd3973;
            4'd4:  v = 32'sd2017;
            4'd5:  v = 32'sd1016;
            4'd6:  v = 32'sd510;
            4'd7:  v = 32'sd256;
            4'd8:  v = 32'sd128;
            4'd9:  v = 32'sd64;
            4'd10: v = 32'sd32;
            4'd11: v = 32'sd16;
            4'd12: v = 32'sd8;
            4'd13: v = 32'sd4;
            4'd14: v = 32'sd2;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // n * ln2 in Q16.16
    function automatic logic signed [31:0] ln_shift(input logic [4:0] n);
        logic signed [31:0] v;
        case (n)
            5'd0:  v = 32'sd0;
            5'd1:  v = 32'sd45426;
            5'd2:  v = 32'sd90852;
            5'd3:  v = 32'sd136278;
            5'd4:  v = 32'sd181704;
            5'd5:  v = 32'sd227130;
            5'd6:  v = 32'sd272557;
            5'd7:  v = 32'sd317983;
            5'd8:  v = 32'sd363409;
            5'd9:  v = 32'sd408835;
            5'd10: v = 32'sd454261;
            5'd11: v = 32'sd499687;
            5'd12: v = 32'sd545113;
            5'd13: v = 32'sd590539;
            5'd14: v = 32'sd635965;
            5'd15: v = 32'sd681391;
            5'd16: v = 32'sd726817;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // k! scaled to Q16.16, as a 34-bit signed divisor
    function automatic logic signed [33:0] fact_fx(input logic [3:0] k);
        logic signed [33:0] v;
        case (k)
            4'd2: v = 34'sd2 <<< 16;
            4'd3: v = 34'sd6 <<< 16;
            4'd4: v = 34'sd24 <<< 16;
            4'd5: v = 34'sd120 <<< 16;
            4'd6: v = 34'sd720 <<< 16;
            4'd7: v = 34'sd5040 <<< 16;
            4'd8: v = 34'sd40320 <<< 16;
            default: v = 34'sd1 <<< 16;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fixed_point_function_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_function_unit: Q16.16 elementary function unit
// sqrt, round, sin, cos, exp, ln, pow, log10, exp10 on one shared multiplier
// and one shared bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                 | tuser
//  --------+-----+------------------------------------+--------------
//  s_      | in  | operand_x[31:0], operand_y[63:32]  | command[3:0]
//  m_      | out | result[31:0]                       | -
//
//  One word at a time. sqrt runs 8 divisions in the divider, ln/log10 up to
//  15, exp/exp10 7, and pow both the ln and the exp series; round and
//  unknown commands skip the divider, and sin/cos use only the multiplier.
//  Reset clears the sequencer and the output valid. A finished word waits
//  in the output register; the next input word is taken meanwhile, and the
//  sequencer holds at its end until the output register frees up.

module fixed_point_function_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // operand_x[31:0], operand_y[63:32]
    input  wire logic [3:0]  s_tuser,   // command[3:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // result[31:0]
);

    fpfu_pkg::state_t state_reg, state_next;

    logic [3:0]         cmd_reg;
    logic signed [31:0] x_reg, y_reg, a_reg, g_reg, p_reg;
    logic signed [31:0] x2_reg, x4_reg, x6_reg, res_reg;
    logic               neg_reg;
    logic [3:0]         k_reg;
    logic [4:0]         sh_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b, mul_res;
    logic signed [63:0] prod;

    // shared divider
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_q;
    logic signed [33:0] div_den;

    logic signed [31:0] ln_thr;
    logic               s_fire, out_free;

    assign prod     = mul_a * mul_b;
    assign mul_res  = prod[47:16];
    assign ln_thr   = fpfu_pkg::FX_ONE + $signed({16'd0, fpfu_pkg::LN_D0 >> k_reg});
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    fpfu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    // round one magnitude: add 1.0 on a set half bit, clear the fraction
    function automatic logic signed [31:0] round_mag(input logic signed [31:0] m);
        logic [31:0] t;
        t = m[15] ? (m + 32'sh10000) : m;
        return $signed(t & 32'hFFFF0000);
    endfunction

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fpfu_pkg::ST_IDLE: begin
                if (s_fire) state_next = fpfu_pkg::ST_DISPATCH;
            end
            fpfu_pkg::ST_DISPATCH: begin
                case (cmd_reg)
                    fpfu_pkg::CMD_SQRT:  state_next = fpfu_pkg::ST_SQ_DS;
                    fpfu_pkg::CMD_SIN,
                    fpfu_pkg::CMD_COS:   state_next = fpfu_pkg::ST_TR_FOLD;
                    fpfu_pkg::CMD_EXP:   state_next = fpfu_pkg::ST_EX_INIT;
                    fpfu_pkg::CMD_EXP10: state_next = fpfu_pkg::ST_EX10;
                    fpfu_pkg::CMD_LN,
                    fpfu_pkg::CMD_LOG10: state_next = fpfu_pkg::ST_LN_PRE;
                    fpfu_pkg::CMD_POW: begin
                        state_next = (x_reg == '0 || y_reg == '0) ? fpfu_pkg::ST_OUT
                                                                  : fpfu_pkg::ST_LN_PRE;
                    end
                    default:             state_next = fpfu_pkg::ST_OUT;
                endcase
            end
            fpfu_pkg::ST_SQ_DS: state_next = fpfu_pkg::ST_SQ_DW;
            fpfu_pkg::ST_SQ_DW: begin
                if (div_done)
                    state_next = (k_reg == 4'd7) ? fpfu_pkg::ST_OUT : fpfu_pkg::ST_SQ_DS;
            end
            fpfu_pkg::ST_TR_FOLD: state_next = fpfu_pkg::ST_TR_SQ;
            fpfu_pkg::ST_TR_SQ:   state_next = fpfu_pkg::ST_TR_M1;
            fpfu_pkg::ST_TR_M1:   state_next = fpfu_pkg::ST_TR_M2;
            fpfu_pkg::ST_TR_M2: begin
                state_next = (cmd_reg == fpfu_pkg::CMD_SIN) ? fpfu_pkg::ST_TR_M3
                                                            : fpfu_pkg::ST_TR_END;
            end
            fpfu_pkg::ST_TR_M3:   state_next = fpfu_pkg::ST_TR_END;
            fpfu_pkg::ST_TR_END:  state_next = fpfu_pkg::ST_OUT;
            fpfu_pkg::ST_EX10:    state_next = fpfu_pkg::ST_EX_INIT;
            fpfu_pkg::ST_EX_INIT: state_next = fpfu_pkg::ST_EX_POW;
            fpfu_pkg::ST_EX_POW:  state_next = fpfu_pkg::ST_EX_DS;
            fpfu_pkg::ST_EX_DS:   state_next = fpfu_pkg::ST_EX_DW;
            fpfu_pkg::ST_EX_DW: begin
                if (div_done)
                    state_next = (k_reg == 4'd8) ? fpfu_pkg::ST_OUT : fpfu_pkg::ST_EX_POW;
            end
            fpfu_pkg::ST_LN_PRE: begin
                if (!(x_reg > fpfu_pkg::FX_TWO && sh_reg < 5'd16))
                    state_next = fpfu_pkg::ST_LN_CHK;
            end
            fpfu_pkg::ST_LN_CHK: begin
                if (x_reg > ln_thr)
                    state_next = fpfu_pkg::ST_LN_DS;
                else if (k_reg == 4'd14)
                    state_next = fpfu_pkg::ST_LN_FIN;
            end
            fpfu_pkg::ST_LN_DS: state_next = fpfu_pkg::ST_LN_DW;
            fpfu_pkg::ST_LN_DW: begin
                if (div_done)
                    state_next = (k_reg == 4'd14) ? fpfu_pkg::ST_LN_FIN : fpfu_pkg::ST_LN_CHK;
            end
            fpfu_pkg::ST_LN_FIN: begin
                state_next = (cmd_reg == fpfu_pkg::CMD_LN) ? fpfu_pkg::ST_OUT
                                                           : fpfu_pkg::ST_LN_POST;
            end
            fpfu_pkg::ST_LN_POST: begin
                state_next = (cmd_reg == fpfu_pkg::CMD_LOG10) ? fpfu_pkg::ST_OUT
                                                              : fpfu_pkg::ST_EX_INIT;
            end
            fpfu_pkg::ST_OUT: begin
                if (out_free) state_next = fpfu_pkg::ST_IDLE;
            end
            default: state_next = fpfu_pkg::ST_IDLE;
        endcase
    end

    // ---- outputs: operand steering for the shared units ----
    always_comb begin
        mul_a     = g_reg;
        mul_b     = p_reg;
        div_start = 1'b0;
        div_num   = x_reg;
        div_den   = {{2{g_reg[31]}}, g_reg};
        case (state_reg)
            fpfu_pkg::ST_EX10: begin
                mul_a = x_reg;
                mul_b = fpfu_pkg::FX_LN_10;
            end
            fpfu_pkg::ST_TR_SQ: begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
            fpfu_pkg::ST_TR_M1: begin
                mul_a = (cmd_reg == fpfu_pkg::CMD_SIN) ? fpfu_pkg::SIN_K1 : fpfu_pkg::COS_K1;
                mul_b = p_reg;
            end
            fpfu_pkg::ST_TR_M3: begin
                mul_a = g_reg;
                mul_b = a_reg;
            end
            fpfu_pkg::ST_EX_POW: begin
                case (k_reg)
                    4'd2:    begin mul_a = a_reg;  mul_b = a_reg;  end
                    4'd3:    begin mul_a = x2_reg; mul_b = a_reg;  end
                    4'd4:    begin mul_a = x2_reg; mul_b = x2_reg; end
                    4'd5:    begin mul_a = x4_reg; mul_b = a_reg;  end
                    4'd6:    begin mul_a = x4_reg; mul_b = x2_reg; end
                    4'd7:    begin mul_a = x6_reg; mul_b = a_reg;  end
                    default: begin mul_a = x4_reg; mul_b = x4_reg; end
                endcase
            end
            fpfu_pkg::ST_LN_POST: begin
                mul_a = (cmd_reg == fpfu_pkg::CMD_LOG10) ? fpfu_pkg::FX_LOG10_E : y_reg;
                mul_b = g_reg;
            end
            fpfu_pkg::ST_SQ_DS: begin
                div_start = 1'b1;
            end
            fpfu_pkg::ST_EX_DS: begin
                div_start = 1'b1;
                div_num   = p_reg;
                div_den   = fpfu_pkg::fact_fx(k_reg);
            end
            fpfu_pkg::ST_LN_DS: begin
                div_start = 1'b1;
                div_den   = {{2{ln_thr[31]}}, ln_thr};
            end
            default: begin
            end
        endcase
    end

    // ---- sequencer state and handshake ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fpfu_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == fpfu_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge aclk) begin
        case (state_reg)
            fpfu_pkg::ST_IDLE: begin
                if (s_fire) begin
                    cmd_reg <= s_tuser;
                    x_reg   <= s_tdata[31:0];
                    y_reg   <= s_tdata[63:32];
                end
            end
            fpfu_pkg::ST_DISPATCH: begin
                // seed every flow; only the chosen one uses these
                g_reg   <= (x_reg + fpfu_pkg::FX_ONE) >>> 1;
                a_reg   <= x_reg;
                k_reg   <= '0;
                sh_reg  <= '0;
                case (cmd_reg)
                    fpfu_pkg::CMD_ROUND: begin
                        res_reg <= (x_reg > 0) ? round_mag(x_reg)
                                               : -round_mag(-x_reg);
                    end
                    fpfu_pkg::CMD_POW: begin
                        g_reg   <= '0;
                        res_reg <= (x_reg == '0) ? '0 : fpfu_pkg::FX_ONE;
                    end
                    fpfu_pkg::CMD_LN,
                    fpfu_pkg::CMD_LOG10: g_reg <= '0;
                    default: res_reg <= '0;
                endcase
            end
            fpfu_pkg::ST_SQ_DW: begin
                if (div_done) begin
                    g_reg   <= (g_reg + div_q) >>> 1;
                    res_reg <= (g_reg + div_q) >>> 1;
                    k_reg   <= k_reg + 4'd1;
                end
            end
            fpfu_pkg::ST_TR_FOLD: begin
                // fold into the first quadrant; track the sign of the answer
                logic signed [31:0] f;
                logic               ng;
                f  = x_reg[31] ? -x_reg : x_reg;
                ng = (cmd_reg == fpfu_pkg::CMD_SIN) && x_reg[31];
                if (f > fpfu_pkg::FX_PI_HALF && f <= fpfu_pkg::FX_PI) begin
                    f  = fpfu_pkg::FX_PI - f;
                    ng = (cmd_reg == fpfu_pkg::CMD_SIN) ? ng : 1'b1;
                end else if (f > fpfu_pkg::FX_PI && f <= fpfu_pkg::FX_PI_3H) begin
                    f  = f - fpfu_pkg::FX_PI;
                    ng = (cmd_reg == fpfu_pkg::CMD_SIN) ? !ng : 1'b1;
                end else if (f > fpfu_pkg::FX_PI_3H) begin
                    f  = fpfu_pkg::FX_PI_2 - f;
                    ng = (cmd_reg == fpfu_pkg::CMD_SIN) ? !ng : ng;
                end
                a_reg   <= f;
                neg_reg <= ng;
            end
            fpfu_pkg::ST_TR_SQ: p_reg <= mul_res;
            fpfu_pkg::ST_TR_M1: begin
                g_reg <= mul_res - ((cmd_reg == fpfu_pkg::CMD_SIN) ? fpfu_pkg::SIN_K2
                                                                   : fpfu_pkg::COS_K2);
            end
            fpfu_pkg::ST_TR_M2: g_reg <= mul_res + fpfu_pkg::FX_ONE;
            fpfu_pkg::ST_TR_M3: g_reg <= mul_res;
            fpfu_pkg::ST_TR_END: res_reg <= neg_reg ? -g_reg : g_reg;
            fpfu_pkg::ST_EX10: a_reg <= mul_res;
            fpfu_pkg::ST_EX_INIT: begin
                g_reg <= a_reg + fpfu_pkg::FX_ONE;
                k_reg <= 4'd2;
            end
            fpfu_pkg::ST_EX_POW: begin
                p_reg <= mul_res;
                if (k_reg == 4'd2) x2_reg <= mul_res;
                if (k_reg == 4'd4) x4_reg <= mul_res;
                if (k_reg == 4'd6) x6_reg <= mul_res;
            end
            fpfu_pkg::ST_EX_DW: begin
                if (div_done) begin
                    g_reg   <= g_reg + div_q;
                    res_reg <= g_reg + div_q;
                    k_reg   <= k_reg + 4'd1;
                end
            end
            fpfu_pkg::ST_LN_PRE: begin
                if (x_reg > fpfu_pkg::FX_TWO && sh_reg < 5'd16) begin
                    x_reg  <= x_reg >>> 1;
                    sh_reg <= sh_reg + 5'd1;
                end
            end
            fpfu_pkg::ST_LN_CHK: begin
                if (!(x_reg > ln_thr) && k_reg != 4'd14) k_reg <= k_reg + 4'd1;
            end
            fpfu_pkg::ST_LN_DW: begin
                if (div_done) begin
                    x_reg <= div_q;
                    g_reg <= g_reg + fpfu_pkg::ln_step(k_reg);
                    if (k_reg != 4'd14) k_reg <= k_reg + 4'd1;
                end
            end
            fpfu_pkg::ST_LN_FIN: begin
                g_reg   <= g_reg + fpfu_pkg::ln_shift(sh_reg);
                res_reg <= g_reg + fpfu_pkg::ln_shift(sh_reg);
            end
            fpfu_pkg::ST_LN_POST: begin
                a_reg   <= mul_res;
                res_reg <= mul_res;
            end
            fpfu_pkg::ST_OUT: begin
                if (out_free) m_tdata_reg <= res_reg;
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == fpfu_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- assertions ----
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == fpfu_pkg::ST_SQ_DW || state_reg == fpfu_pkg::ST_EX_DW
                      || state_reg == fpfu_pkg::ST_LN_DW))
        else $error("divider finished outside a wait state");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == fpfu_pkg::ST_DISPATCH))
        else $error("accepted word not dispatched");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == fpfu_pkg::ST_OUT))
        else $error("result word raised outside the output state");

endmodule
`default_nettype wire

// ===== hw/rtl/fpfu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfu_div: bit-serial Q16.16 divider
// Computes (num << 16) / den truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fpfu_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [33:0] den,
    output logic                    done,
    output logic signed [31:0]      quo
);

    logic        busy_reg, done_reg, zero_reg, neg_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg, den_reg;
    logic [47:0] quo_reg;
    logic [33:0] trial;
    logic        ge;
    logic [32:0] num_mag;
    logic [33:0] den_mag;

    assign num_mag = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};
    assign den_mag = den[33] ? (34'd0 - den) : den;
    assign trial   = {rem_reg, quo_reg[47]};
    assign ge      = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                zero_reg <= (den == '0);
                neg_reg  <= num[31] ^ den[33];
                quo_reg  <= {num_mag[31:0], 16'd0};
                den_reg  <= den_mag[32:0];
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= (den != '0);
                done_reg <= (den == '0);
            end else if (busy_reg) begin
                rem_reg <= ge ? (trial[32:0] - den_reg) : trial[32:0];
                quo_reg <= {quo_reg[46:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? 32'sh7FFFFFFF
                : (neg_reg ? -$signed(quo_reg[31:0]) : $signed(quo_reg[31:0]));

endmodule
`default_nettype wire
